/* rtl/xpfp_pkg.sv */
package xpfp_pkg;

  // Item selector codes; the fourth code is reserved and ignored.
  localparam logic [1:0] FUNC_FEEDBACK = 2'd0;
  localparam logic [1:0] FUNC_START    = 2'd1;
  localparam logic [1:0] FUNC_PAYLOAD  = 2'd2;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_PARITY = 1'b1;

  localparam logic [3:0] GS_MIN   = 4'd2;
  localparam logic [3:0] GS_MAX   = 4'd12;
  localparam logic [3:0] GS_RESET = 4'd6;

  localparam logic [3:0] HDR_BYTES  = 4'd6;
  localparam logic [3:0] WORD_BYTES = 4'd8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PHDR,
    ST_PWORD,
    ST_DHDR
  } state_e;

  // Control handed to the row of parity cells.
  typedef struct packed {
    logic shift;
    logic wr;
  } store_ctl_t;

  function automatic logic [63:0] header_word(logic kind, logic [31:0] seq,
                                              logic [3:0] size);
    header_word = {16'h0, 4'h0, size, seq[7:0], seq[15:8], seq[23:16],
                   seq[31:24], 7'h0, kind};
  endfunction

  function automatic logic [3:0] clamp_size(logic [7:0] req);
    if (req < {4'h0, GS_MIN}) begin
      clamp_size = GS_MIN;
    end else if (req > {4'h0, GS_MAX}) begin
      clamp_size = GS_MAX;
    end else begin
      clamp_size = req[3:0];
    end
  endfunction

endpackage

/* rtl/xpfp_in_if.sv */
interface xpfp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [7:0]  byte_value;
  logic [31:0] sequence_req;
  logic        frame_end;

  modport source (output valid, output func, output byte_value,
                  output sequence_req, output frame_end, input ready);
  modport sink (input valid, input func, input byte_value,
                input sequence_req, input frame_end, output ready);
endinterface

/* rtl/xpfp_out_if.sv */
interface xpfp_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] wire_word;
  logic [3:0]  byte_count;
  logic        packet_kind;
  logic        packet_end;

  modport source (output valid, output wire_word, output byte_count,
                  output packet_kind, output packet_end, input ready);
  modport sink (input valid, input wire_word, input byte_count,
                input packet_kind, input packet_end, output ready);
endinterface

/* rtl/xpfp_cell.sv */
module xpfp_cell import xpfp_pkg::*; #(
  parameter int IDX = 0,
  parameter int PW  = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  store_ctl_t    ctl_i,
  input  logic [PW-1:0] pos_i,
  input  logic [7:0]    byte_i,
  input  logic [7:0]    shift_i,
  output logic [7:0]    value_o
);

  logic [7:0] val_q, val_d;

  // Shift wins: during a parity burst no payload is written.
  always_comb begin
    val_d = val_q;
    if (ctl_i.shift) begin
      val_d = shift_i;
    end else if (ctl_i.wr && (pos_i == PW'(IDX))) begin
      val_d = val_q ^ byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= 8'h0;
    end else begin
      val_q <= val_d;
    end
  end

  assign value_o = val_q;

endmodule

/* rtl/xpfp_store.sv */
module xpfp_store import xpfp_pkg::*; #(
  parameter int FRAME_BYTES = 160
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  store_ctl_t                              ctl_i,
  input  logic [$clog2(((FRAME_BYTES+7)/8)*8+1)-1:0] pos_i,
  input  logic [7:0]                              byte_i,
  output logic [63:0]                             head_o
);

  localparam int NCELL = ((FRAME_BYTES + 7) / 8) * 8;
  localparam int PW    = $clog2(NCELL + 1);

  logic [7:0] val [NCELL];

  // Each cell takes the byte eight places up on a shift; the tail fills with zero.
  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    logic [7:0] nxt;
    if (k + 8 < NCELL) begin : g_mid
      assign nxt = val[k+8];
    end else begin : g_tail
      assign nxt = 8'h0;
    end
    xpfp_cell #(.IDX(k), .PW(PW)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl_i),
      .pos_i  (pos_i),
      .byte_i (byte_i),
      .shift_i(nxt),
      .value_o(val[k])
    );
  end

  for (genvar j = 0; j < 8; j++) begin : g_head
    assign head_o[8*j +: 8] = val[j];
  end

endmodule

/* rtl/xor_parity_fec_packetizer_core.sv */
// XOR parity FEC packetizer.
// in_i carries feedback (new group size, clamped to 2..12), frame starts with
// a sequence number, and payload bytes. out_o carries wire words of up to
// eight bytes, first byte in bits 7:0, with a byte count, a packet kind and
// an end-of-packet flag. A transfer happens when valid and ready are high.
// Each frame start gives a 6-byte data header word and each payload byte a
// one-byte word, registered and shown in the cycle after the input transfer
// (a header deferred behind parity apart); payload streams at one byte per
// cycle while out_o is ready. When a frame closes the group full, a parity
// burst of 1 + ceil(FRAME_BYTES/8) words follows, one word per cycle while
// out_o is ready, and in_i.ready stays low for that burst and for the
// deferred data header when a start closes an open frame that fills the group.
// A word counter sets the burst length; the row of parity cells shifts eight
// bytes to its head per word and zero-fills the tail, leaving the store clear.
// A stalled receiver holds the output register; ready drops until the word
// is taken, and no input is transferred meanwhile.
// Reset clears the parity cells, the group count and any open frame, and
// sets the group size to 6.
module xor_parity_fec_packetizer_core import xpfp_pkg::*; #(
  parameter int FRAME_BYTES = 160
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  xpfp_in_if.sink           in_i,
  xpfp_out_if.source        out_o
);

  localparam int NW    = (FRAME_BYTES + 7) / 8;
  localparam int NCELL = NW * 8;
  localparam int PW    = $clog2(NCELL + 1);
  localparam int WCW   = (NW > 1) ? $clog2(NW) : 1;
  localparam logic [3:0] LAST_CNT = ((FRAME_BYTES % 8) == 0) ? 4'd8 :
                                    4'(FRAME_BYTES % 8);

  state_e        state_q, state_d;
  logic [3:0]    gs_q, gs_d;
  logic [3:0]    fig_q, fig_d;
  logic [31:0]   gfs_q, gfs_d;
  logic [PW-1:0] pos_q, pos_d;
  logic          open_q, open_d;
  logic          pend_q, pend_d;
  logic [31:0]   seq_q, seq_d;
  logic          fend_q, fend_d;
  logic [WCW-1:0] wc_q, wc_d;
  logic          ov_q, ov_d;
  logic [63:0]   ow_q, ow_d;
  logic [3:0]    oc_q, oc_d;
  logic          ok_q, ok_d;
  logic          oe_q, oe_d;

  logic          emit;
  logic [63:0]   e_word;
  logic [3:0]    e_cnt;
  logic          e_kind;
  logic          e_end;
  store_ctl_t    sctl;
  logic [63:0]   head_w;

  logic          out_free, in_acc, is_start, is_pay, wc_last;
  logic [3:0]    fig_open;
  logic          par_pre, par_start_end, par_pay;

  // Output register frees when empty or when its word transfers this cycle.
  assign out_free = !ov_q || out_o.ready;
  assign in_i.ready = (state_q == ST_IDLE) && out_free;
  assign in_acc   = in_i.valid && in_i.ready;
  assign is_start = in_acc && (in_i.func == FUNC_START);
  assign is_pay   = in_acc && (in_i.func == FUNC_PAYLOAD) && open_q;
  assign wc_last  = (wc_q == WCW'(NW - 1));

  // A frame start closes any open frame first.
  assign fig_open = open_q ? (fig_q + 4'd1) : fig_q;
  assign par_pre  = is_start && open_q && (fig_open >= gs_q);
  assign par_start_end = is_start && !par_pre && in_i.frame_end &&
                         ((fig_open + 4'd1) >= gs_q);
  assign par_pay  = is_pay && in_i.frame_end && ((fig_q + 4'd1) >= gs_q);

  xpfp_store #(.FRAME_BYTES(FRAME_BYTES)) u_store (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (sctl),
    .pos_i (pos_q),
    .byte_i(in_i.byte_value),
    .head_o(head_w)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (par_pre || par_start_end || par_pay) begin
          state_d = ST_PHDR;
        end
      end
      ST_PHDR: begin
        if (out_free) begin
          state_d = ST_PWORD;
        end
      end
      ST_PWORD: begin
        if (out_free && wc_last) begin
          state_d = pend_q ? ST_DHDR : ST_IDLE;
        end
      end
      ST_DHDR: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and emitted words.
  always_comb begin
    gs_d   = gs_q;
    fig_d  = fig_q;
    gfs_d  = gfs_q;
    pos_d  = pos_q;
    open_d = open_q;
    pend_d = pend_q;
    seq_d  = seq_q;
    fend_d = fend_q;
    wc_d   = wc_q;
    emit   = 1'b0;
    e_word = 64'h0;
    e_cnt  = HDR_BYTES;
    e_kind = KIND_DATA;
    e_end  = 1'b0;
    sctl   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_i.func)
            FUNC_FEEDBACK: begin
              gs_d = clamp_size(in_i.byte_value);
            end
            FUNC_START: begin
              if (par_pre) begin
                // Parity goes out first; hold the new header for later.
                fig_d  = 4'd0;
                open_d = 1'b0;
                pend_d = 1'b1;
                seq_d  = in_i.sequence_req;
                fend_d = in_i.frame_end;
              end else begin
                emit   = 1'b1;
                e_word = header_word(KIND_DATA, in_i.sequence_req, gs_q);
                e_end  = in_i.frame_end;
                pos_d  = '0;
                if (fig_open == 4'd0) begin
                  gfs_d = in_i.sequence_req;
                end
                if (in_i.frame_end) begin
                  open_d = 1'b0;
                  fig_d  = par_start_end ? 4'd0 : (fig_open + 4'd1);
                end else begin
                  open_d = 1'b1;
                  fig_d  = fig_open;
                end
              end
            end
            FUNC_PAYLOAD: begin
              if (open_q) begin
                emit   = 1'b1;
                e_word = {56'h0, in_i.byte_value};
                e_cnt  = 4'd1;
                e_end  = in_i.frame_end;
                if (pos_q < PW'(FRAME_BYTES)) begin
                  sctl.wr = 1'b1;
                  pos_d   = pos_q + PW'(1);
                end
                if (in_i.frame_end) begin
                  open_d = 1'b0;
                  fig_d  = par_pay ? 4'd0 : (fig_q + 4'd1);
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_PHDR: begin
        if (out_free) begin
          emit   = 1'b1;
          e_word = header_word(KIND_PARITY, gfs_q, gs_q);
          e_kind = KIND_PARITY;
          wc_d   = '0;
        end
      end
      ST_PWORD: begin
        if (out_free) begin
          emit       = 1'b1;
          e_word     = head_w;
          e_cnt      = wc_last ? LAST_CNT : WORD_BYTES;
          e_kind     = KIND_PARITY;
          e_end      = wc_last;
          sctl.shift = 1'b1;
          wc_d       = wc_q + WCW'(1);
        end
      end
      ST_DHDR: begin
        if (out_free) begin
          emit   = 1'b1;
          e_word = header_word(KIND_DATA, seq_q, gs_q);
          e_end  = fend_q;
          gfs_d  = seq_q;
          pos_d  = '0;
          pend_d = 1'b0;
          if (fend_q) begin
            // The group was just emptied, so this close cannot fill it.
            fig_d  = 4'd1;
            open_d = 1'b0;
          end else begin
            open_d = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    ov_d = ov_q;
    ow_d = ow_q;
    oc_d = oc_q;
    ok_d = ok_q;
    oe_d = oe_q;
    if (out_free) begin
      ov_d = emit;
    end
    if (emit) begin
      ow_d = e_word;
      oc_d = e_cnt;
      ok_d = e_kind;
      oe_d = e_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      gs_q    <= GS_RESET;
      fig_q   <= 4'd0;
      gfs_q   <= 32'h0;
      pos_q   <= '0;
      open_q  <= 1'b0;
      pend_q  <= 1'b0;
      wc_q    <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      gs_q    <= gs_d;
      fig_q   <= fig_d;
      gfs_q   <= gfs_d;
      pos_q   <= pos_d;
      open_q  <= open_d;
      pend_q  <= pend_d;
      wc_q    <= wc_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seq_q  <= seq_d;
    fend_q <= fend_d;
    ow_q   <= ow_d;
    oc_q   <= oc_d;
    ok_q   <= ok_d;
    oe_q   <= oe_d;
  end

  assign out_o.valid       = ov_q;
  assign out_o.wire_word   = ow_q;
  assign out_o.byte_count  = oc_q;
  assign out_o.packet_kind = ok_q;
  assign out_o.packet_end  = oe_q;

  a_gs_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (gs_q >= GS_MIN) && (gs_q <= GS_MAX))
    else $error("group size out of range");

  a_pos_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PW'(FRAME_BYTES))
    else $error("byte position beyond frame");

  a_burst_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PHDR) && out_free |=> (state_q == ST_PWORD) && (wc_q == '0))
    else $error("parity burst did not start at word zero");

  a_store_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PWORD) && out_free && wc_last |=> (head_w == 64'h0))
    else $error("parity store not clear after burst");

  a_no_input_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PWORD) |-> !in_acc && !open_q)
    else $error("input transfer or open frame during parity burst");

endmodule

/* bench/xor_parity_fec_packetizer_core_tb.sv */
module xor_parity_fec_packetizer_core_tb;
  import xpfp_pkg::*;

  localparam int FRAME_BYTES = 160;

  // The fourth selector code is reserved; the block must drop it silently.
  localparam logic [1:0] FUNC_RESERVED = 2'd3;

  // One wire word as seen on the output channel.
  typedef struct {
    logic [63:0] word;
    logic [3:0]  count;
    logic        kind;
    logic        last;
  } wire_beat_t;

  // Scoreboard: tracks the packetizer state, turns every accepted input
  // transfer into the wire words it must produce, and checks the output
  // transfers against them in order.
  class fec_packet_model #(int NBYTES = 160);
    logic [3:0]  grp_size;
    logic [3:0]  frames_done;
    logic [31:0] first_seq;
    int unsigned pos;
    logic [7:0]  parity [NBYTES];
    bit          open;
    wire_beat_t  expected_words [$];
    int          errors;

    function new();
      grp_size    = GS_RESET;
      frames_done = '0;
      first_seq   = '0;
      pos         = 0;
      open        = 1'b0;
      errors      = 0;
      foreach (parity[i]) parity[i] = '0;
    endfunction

    // Byte 0 is the type, bytes 1..4 the sequence big-endian, byte 5 the size.
    function logic [63:0] hdr(logic kind, logic [31:0] seq, logic [3:0] size);
      logic [63:0] w;
      w        = '0;
      w[7:0]   = {7'h0, kind};
      w[15:8]  = seq[31:24];
      w[23:16] = seq[23:16];
      w[31:24] = seq[15:8];
      w[39:32] = seq[7:0];
      w[47:40] = {4'h0, size};
      return w;
    endfunction

    function void push(logic [63:0] w, logic [3:0] c, logic k, logic e);
      wire_beat_t b;
      b.word  = w;
      b.count = c;
      b.kind  = k;
      b.last  = e;
      expected_words = {expected_words, b};
    endfunction

    function void close_frame();
      logic [63:0] w;
      logic [3:0]  cnt;
      open        = 1'b0;
      frames_done = frames_done + 4'd1;
      if (frames_done < grp_size) return;
      push(hdr(KIND_PARITY, first_seq, grp_size), HDR_BYTES, KIND_PARITY, 1'b0);
      for (int base = 0; base < NBYTES; base += 8) begin
        w   = '0;
        cnt = '0;
        for (int j = 0; j < 8 && base + j < NBYTES; j++) begin
          w[8*j +: 8] = parity[base + j];
          cnt         = cnt + 4'd1;
        end
        push(w, cnt, KIND_PARITY, base + 8 >= NBYTES);
      end
      foreach (parity[i]) parity[i] = '0;
      frames_done = '0;
    endfunction

    function void note_item(logic [1:0] func, logic [7:0] val, logic [31:0] seq,
                            logic fend);
      case (func)
        FUNC_FEEDBACK: begin
          if (val < {4'h0, GS_MIN}) grp_size = GS_MIN;
          else if (val > {4'h0, GS_MAX}) grp_size = GS_MAX;
          else grp_size = val[3:0];
        end
        FUNC_START: begin
          // A start inside an open frame closes that frame first.
          if (open) close_frame();
          if (frames_done == 4'd0) first_seq = seq;
          pos  = 0;
          open = 1'b1;
          push(hdr(KIND_DATA, seq, grp_size), HDR_BYTES, KIND_DATA, fend);
          if (fend) close_frame();
        end
        FUNC_PAYLOAD: begin
          if (open) begin
            // Bytes past the store size go out on the wire but skip parity.
            if (pos < NBYTES) begin
              parity[pos] = parity[pos] ^ val;
              pos++;
            end
            push({56'h0, val}, 4'd1, KIND_DATA, fend);
            if (fend) close_frame();
          end
        end
        default: ;
      endcase
    endfunction

    function void check_word(wire_beat_t got);
      wire_beat_t exp_b;
      if (expected_words.size() == 0) begin
        $error("unexpected wire word %0h (count %0d kind %0d end %0d)",
               got.word, got.count, got.kind, got.last);
        errors++;
        return;
      end
      exp_b = expected_words.pop_front();
      if (got.word !== exp_b.word) begin
        $error("wire_word: expected %0h, actual %0h", exp_b.word, got.word);
        errors++;
      end
      if (got.count !== exp_b.count) begin
        $error("byte_count: expected %0d, actual %0d", exp_b.count, got.count);
        errors++;
      end
      if (got.kind !== exp_b.kind) begin
        $error("packet_kind: expected %0d, actual %0d", exp_b.kind, got.kind);
        errors++;
      end
      if (got.last !== exp_b.last) begin
        $error("packet_end: expected %0d, actual %0d", exp_b.last, got.last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  xpfp_in_if  in_bus ();
  xpfp_out_if out_bus ();

  fec_packet_model #(FRAME_BYTES) model;

  // Idle percentages for each side; the active test phase sets them.
  int send_idle_pct;
  int recv_idle_pct;
  // Non-ignored random items sent so far, and whether the generator left a
  // frame open (a frame with no closing byte).
  int item_count;
  bit frame_open;

  xor_parity_fec_packetizer_core #(.FRAME_BYTES(FRAME_BYTES)) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Receiver: stall at random, re-rolled every cycle.
  always @(posedge clk_i) begin
    out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Monitor both channels at the clock edge. Note the input transfer before
  // checking the output so that a same-edge result would still line up.
  always @(posedge clk_i) begin : monitor
    wire_beat_t beat;
    if (rst_ni) begin
      if (in_bus.valid && in_bus.ready) begin
        model.note_item(in_bus.func, in_bus.byte_value, in_bus.sequence_req,
                        in_bus.frame_end);
      end
      if (out_bus.valid && out_bus.ready) begin
        beat.word  = out_bus.wire_word;
        beat.count = out_bus.byte_count;
        beat.kind  = out_bus.packet_kind;
        beat.last  = out_bus.packet_end;
        model.check_word(beat);
      end
    end
  end

  // Drive one item and hold it until the transfer. Random idle cycles come
  // first; valid is only lowered when such a gap is taken, so back-to-back
  // items keep valid high with a single assignment per edge.
  task automatic send_item(input logic [1:0] func, input logic [7:0] val,
                           input logic [31:0] seq, input logic fend);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid        <= 1'b1;
    in_bus.func         <= func;
    in_bus.byte_value   <= val;
    in_bus.sequence_req <= seq;
    in_bus.frame_end    <= fend;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
  endtask

  // Hold the sender off until every expected word has come out, then let a
  // few more cycles pass so a stray word would still be caught.
  task automatic drain();
    in_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (model.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // One frame: a start, then len payload bytes. A broken frame never sets
  // frame_end, so the next start has to close it.
  task automatic send_frame(input int len, input bit broken);
    logic [31:0] seq;
    seq = $urandom;
    if (len == 0) begin
      send_item(FUNC_START, 8'($urandom_range(255)), seq, !broken);
    end else begin
      send_item(FUNC_START, 8'($urandom_range(255)), seq, 1'b0);
      for (int i = 1; i <= len; i++) begin
        send_item(FUNC_PAYLOAD, 8'($urandom_range(255)), $urandom,
                  (i == len) && !broken);
      end
    end
    frame_open = broken;
    item_count += len + 1;
  endtask

  // Random traffic: mostly well-formed frames with random content and
  // random group sizes, plus feedback, reserved codes and stray payload.
  task automatic run_phase(input int send_pct, input int recv_pct,
                           input int item_goal, input bit long_first);
    int          r;
    int          pick;
    logic [7:0]  fb;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    // Overrun the parity store once so the byte position saturates.
    if (long_first) send_frame($urandom_range(FRAME_BYTES + 10, FRAME_BYTES + 1), 1'b0);
    while (item_count < item_goal) begin
      r = $urandom_range(99);
      if (r < 8) begin
        // Favor small groups so parity bursts come often.
        pick = $urandom_range(9);
        if (pick < 6) fb = 8'($urandom_range(4, 2));
        else if (pick < 8) fb = 8'($urandom_range(GS_MAX + 1, 0));
        else fb = 8'($urandom_range(255));
        send_item(FUNC_FEEDBACK, fb, $urandom, 1'($urandom_range(1)));
        item_count++;
      end else if (r < 14) begin
        // Noise the block must drop: payload outside a frame or a reserved code.
        if (!frame_open && r[0]) begin
          send_item(FUNC_PAYLOAD, 8'($urandom_range(255)), $urandom,
                    1'($urandom_range(1)));
        end else begin
          send_item(FUNC_RESERVED, 8'($urandom_range(255)), $urandom,
                    1'($urandom_range(1)));
        end
      end else begin
        send_frame($urandom_range(12), $urandom_range(99) < 15);
      end
    end
    drain();
  endtask

  initial begin
    rst_ni              = 1'b0;
    in_bus.valid        = 1'b0;
    in_bus.func         = FUNC_FEEDBACK;
    in_bus.byte_value   = '0;
    in_bus.sequence_req = '0;
    in_bus.frame_end    = 1'b0;
    send_idle_pct       = 7;
    recv_idle_pct       = 64;
    item_count          = 0;
    frame_open          = 1'b0;
    model               = new();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: stray payload and reserved code, clamping at both ends,
    // empty frames, a start that closes an open frame, a start that fills
    // the group (parity before the new header), and a group shrunk below
    // the frames already counted.
    send_item(FUNC_PAYLOAD, 8'hFF, 32'h0, 1'b1);
    send_item(FUNC_RESERVED, 8'hFF, 32'hFFFF_FFFF, 1'b1);
    send_item(FUNC_FEEDBACK, 8'h00, 32'h0, 1'b1);
    send_item(FUNC_START, 8'h00, 32'hFFFF_FFFF, 1'b0);
    send_item(FUNC_PAYLOAD, 8'h00, 32'h0, 1'b0);
    send_item(FUNC_PAYLOAD, 8'hFF, 32'h0, 1'b1);
    send_item(FUNC_START, 8'h00, 32'h0, 1'b1);
    send_item(FUNC_FEEDBACK, 8'hFF, 32'h0, 1'b0);
    send_item(FUNC_FEEDBACK, 8'h01, 32'h0, 1'b0);
    send_item(FUNC_FEEDBACK, 8'h0C, 32'h0, 1'b0);
    send_item(FUNC_FEEDBACK, 8'h02, 32'h0, 1'b0);
    send_item(FUNC_START, 8'h00, 32'h1234_5678, 1'b0);
    send_item(FUNC_PAYLOAD, 8'hA5, 32'h0, 1'b0);
    send_item(FUNC_PAYLOAD, 8'h5A, 32'h0, 1'b0);
    send_item(FUNC_START, 8'h00, 32'h8765_4321, 1'b0);
    send_item(FUNC_PAYLOAD, 8'h3C, 32'h0, 1'b1);
    send_item(FUNC_START, 8'h00, 32'h0000_00C0, 1'b1);
    send_item(FUNC_START, 8'h00, 32'h0000_00D0, 1'b0);
    send_item(FUNC_PAYLOAD, 8'h77, 32'h0, 1'b0);
    send_item(FUNC_START, 8'h00, 32'h0000_00E0, 1'b0);
    send_item(FUNC_PAYLOAD, 8'h81, 32'h0, 1'b1);
    send_item(FUNC_FEEDBACK, 8'h06, 32'h0, 1'b0);
    send_item(FUNC_START, 8'h00, 32'hA000_0001, 1'b1);
    send_item(FUNC_START, 8'h00, 32'hA000_0002, 1'b1);
    send_item(FUNC_FEEDBACK, 8'h02, 32'h0, 1'b0);
    send_item(FUNC_START, 8'h00, 32'hA000_0003, 1'b1);

    run_phase(7, 64, 80, 1'b0);
    run_phase(64, 7, 300, 1'b1);
    run_phase(0, 0, 350, 1'b0);

    // Everything has drained; watch a while longer for stray words.
    repeat (40) @(posedge clk_i);
    if (model.errors == 0) begin
      $display("xor_parity_fec_packetizer_core regression: pass");
    end else begin
      $display("xor_parity_fec_packetizer_core regression: fail");
    end
    $finish;
  end

  // Watchdog: abort a hung run.
  initial begin
    #5000000;
    $display("xor_parity_fec_packetizer_core regression: fail");
    $finish;
  end

endmodule

/* files.f */
rtl/xpfp_pkg.sv
rtl/xpfp_in_if.sv
rtl/xpfp_out_if.sv
rtl/xpfp_cell.sv
rtl/xpfp_store.sv
rtl/xor_parity_fec_packetizer_core.sv
bench/xor_parity_fec_packetizer_core_tb.sv
